// ===== design/tsw_pkg.sv =====
// ----------------------------------------------------------------------------
// tsw_pkg
// shared types, constants and helpers of the terrain splat weight pipeline
// ----------------------------------------------------------------------------
package tsw_pkg;

  // defaults of the top level parameters
  localparam int unsigned HEIGHT_WIDTH_DEF = 24;
  localparam int unsigned WEIGHT_FRAC_DEF  = 15;

  // fixed field widths
  localparam int unsigned REG_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SED_W     = 23;
  localparam int unsigned FLOW_W    = 16;
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned Q_FRAC    = 8;

  // slope root datapath
  localparam int unsigned SQ_W       = 30;
  localparam int unsigned SQ2_W      = 2 * SQ_W;
  localparam int unsigned SQ_SUM_W   = SQ2_W + 1;
  localparam int unsigned EXP_W      = 2;
  localparam int unsigned ROOT_IN_W  = 62;
  localparam int unsigned ROOT_STEPS = ROOT_IN_W / 2;
  localparam int unsigned ROOT_W     = ROOT_STEPS;
  localparam int unsigned SHR_W      = 4;
  localparam int unsigned ROOT_FRAC  = 6;
  localparam int unsigned SLOPE_W    = ROOT_W + 9;
  localparam int unsigned HI_W       = SLOPE_W + 7;
  localparam int unsigned T_W        = REG_W + 1;

  // rock ramp: (100*s - 2304*t) / (3072*t)
  localparam int unsigned ROCK_GAIN    = 100;
  localparam int unsigned ROCK_LO_MUL  = 2304;
  localparam int unsigned ROCK_DEN_MUL = 3072;

  // dividers
  localparam int unsigned DIV_W      = 37;
  localparam int unsigned HDIV_W     = REG_W;
  localparam int unsigned LANES      = 2;
  localparam int unsigned LANE_ROCK  = 0;
  localparam int unsigned LANE_HGT   = 1;

  // flow and sediment
  localparam int unsigned FLOW_SHIFT   = 9;
  localparam int unsigned SED_SAT_LIM  = 768;
  localparam int unsigned SED_KEEP     = 10;
  localparam int unsigned SEDV_W       = SED_KEEP + Q_FRAC;
  localparam int unsigned SED_RECIP_W  = 23;
  localparam logic [SED_RECIP_W-1:0] SED_RECIP = 23'd5592406;
  localparam int unsigned SED_RECIP_SH = 24;
  localparam int unsigned SED_PROD_W   = SEDV_W + SED_RECIP_W;

  // register reset values
  localparam logic [REG_W-1:0] CELL_SIZE_RST    = 24'd256;
  localparam logic [REG_W-1:0] HEIGHT_SCALE_RST = 24'd10240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SIZE    = 3'd0,
    REG_RANGE_LOW    = 3'd1,
    REG_RANGE_HIGH   = 3'd2,
    REG_RANGE_VALID  = 3'd3,
    REG_HEIGHT_SCALE = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [REG_W-1:0]        cell_size;
    logic signed [REG_W-1:0] range_low;
    logic signed [REG_W-1:0] range_high;
    logic                    range_valid;
    logic [REG_W-1:0]        height_scale;
  } cfg_t;

  // words travelling alongside the slope root
  typedef struct packed {
    logic [SHR_W-1:0]    root_shift;
    logic [HDIV_W-1:0]   h_num;
    logic [HDIV_W-1:0]   h_den;
    logic                h_zero;
    logic                h_sat;
    logic [WEIGHT_W-1:0] flow_w;
    logic [WEIGHT_W-1:0] sed_w;
  } front_side_t;

  // words travelling alongside the dividers
  typedef struct packed {
    logic                r_zero;
    logic                r_sat;
    logic                h_zero;
    logic                h_sat;
    logic [WEIGHT_W-1:0] flow_w;
    logic [WEIGHT_W-1:0] sed_w;
  } div_side_t;

  // full scale weight, clipped to the 16 bit field
  function automatic logic [WEIGHT_W-1:0] weight_limit(int unsigned frac);
    logic [WEIGHT_W-1:0] lim;
    if (frac > WEIGHT_W - 1) begin
      lim = '1;
    end else begin
      lim = WEIGHT_W'(32'd1 << frac);
    end
    return lim;
  endfunction

endpackage

// ===== design/tsw_if.sv =====
// ----------------------------------------------------------------------------
// tsw interfaces
// valid/ready channels for cell words, weight words and register writes
// ----------------------------------------------------------------------------
interface tsw_in_if #(
  parameter int unsigned HEIGHT_WIDTH = tsw_pkg::HEIGHT_WIDTH_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [HEIGHT_WIDTH-1:0]   center_height;
  logic signed [HEIGHT_WIDTH-1:0]   left_height;
  logic signed [HEIGHT_WIDTH-1:0]   right_height;
  logic signed [HEIGHT_WIDTH-1:0]   lower_height;
  logic signed [HEIGHT_WIDTH-1:0]   upper_height;
  logic [tsw_pkg::SED_W-1:0]        sediment_depth;
  logic [tsw_pkg::FLOW_W-1:0]       flow_level;

  modport source (
    output valid, center_height, left_height, right_height, lower_height,
           upper_height, sediment_depth, flow_level,
    input  ready
  );
  modport sink (
    input  valid, center_height, left_height, right_height, lower_height,
           upper_height, sediment_depth, flow_level,
    output ready
  );
endinterface

interface tsw_res_if;
  logic                         valid;
  logic                         ready;
  logic [tsw_pkg::WEIGHT_W-1:0] rock_weight;
  logic [tsw_pkg::WEIGHT_W-1:0] height_weight;
  logic [tsw_pkg::WEIGHT_W-1:0] flow_weight;
  logic [tsw_pkg::WEIGHT_W-1:0] sediment_weight;

  modport source (
    output valid, rock_weight, height_weight, flow_weight, sediment_weight,
    input  ready
  );
  modport sink (
    input  valid, rock_weight, height_weight, flow_weight, sediment_weight,
    output ready
  );
endinterface

interface tsw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tsw_pkg::CFG_IDX_W-1:0] index;
  logic [tsw_pkg::REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/tsw_front.sv =====
// ----------------------------------------------------------------------------
// tsw_front
// five stage front end: gradients, height/flow/sediment weights, root operand
// ----------------------------------------------------------------------------
module tsw_front #(
  parameter int unsigned HEIGHT_WIDTH     = tsw_pkg::HEIGHT_WIDTH_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = tsw_pkg::WEIGHT_FRAC_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tsw_pkg::cfg_t                      cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [HEIGHT_WIDTH-1:0]     center_i,
  input  logic signed [HEIGHT_WIDTH-1:0]     left_i,
  input  logic signed [HEIGHT_WIDTH-1:0]     right_i,
  input  logic signed [HEIGHT_WIDTH-1:0]     lower_i,
  input  logic signed [HEIGHT_WIDTH-1:0]     upper_i,
  input  logic [tsw_pkg::SED_W-1:0]          sed_i,
  input  logic [tsw_pkg::FLOW_W-1:0]         flow_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tsw_pkg::ROOT_IN_W-1:0]      radicand_o,
  output tsw_pkg::front_side_t               side_o
);

  localparam int unsigned NST  = 5;
  localparam int unsigned DW   = HEIGHT_WIDTH + 1;
  localparam int unsigned AW   = HEIGHT_WIDTH + 1;
  localparam int unsigned HXW  = ((HEIGHT_WIDTH > tsw_pkg::REG_W) ?
                                  HEIGHT_WIDTH : tsw_pkg::REG_W) + 2;
  localparam int unsigned EMAX = (AW > tsw_pkg::SQ_W) ? AW - tsw_pkg::SQ_W : 0;
  localparam int unsigned FXW  = tsw_pkg::FLOW_W + WEIGHT_FRAC_BITS;
  localparam logic [tsw_pkg::WEIGHT_W-1:0] WLIM =
    tsw_pkg::weight_limit(WEIGHT_FRAC_BITS);

  logic [NST-1:0] v_q;
  logic [NST-1:0] stall;

  // stage a
  logic signed [DW-1:0]           dx_a_q, dy_a_q;
  logic signed [HEIGHT_WIDTH-1:0] h_a_q;
  logic [tsw_pkg::SED_W-1:0]      sed_a_q;
  logic [tsw_pkg::FLOW_W-1:0]     flow_a_q;
  // stage b
  logic [AW-1:0]                  ax_b_q, ay_b_q;
  logic                           sed_sat_b_q;
  logic [tsw_pkg::SEDV_W-1:0]     sedv_b_q;
  tsw_pkg::front_side_t           side_b_q;
  // stage c
  logic [tsw_pkg::SQ_W-1:0]       bx_c_q, by_c_q;
  logic [tsw_pkg::EXP_W-1:0]      e_c_q;
  logic                           sed_sat_c_q;
  logic [tsw_pkg::SED_PROD_W-1:0] sedp_c_q;
  tsw_pkg::front_side_t           side_c_q;
  // stage d
  logic [tsw_pkg::SQ2_W-1:0]      sqx_d_q, sqy_d_q;
  logic [tsw_pkg::EXP_W-1:0]      e_d_q;
  tsw_pkg::front_side_t           side_d_q;
  // stage e
  logic [tsw_pkg::ROOT_IN_W-1:0]  n_e_q;
  tsw_pkg::front_side_t           side_e_q;

  // hold chain
  always_comb begin
    stall[NST-1] = v_q[NST-1] && out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      stall[k] = v_q[k] && stall[k+1];
    end
  end

  assign in_stall_o  = stall[0];
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (!stall[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
        end
      end
    end
  end

  // stage a: gradients
  always_ff @(posedge clk_i) begin
    if (!stall[0] && in_valid_i) begin
      dx_a_q   <= DW'(right_i) - DW'(left_i);
      dy_a_q   <= DW'(upper_i) - DW'(lower_i);
      h_a_q    <= center_i;
      sed_a_q  <= sed_i;
      flow_a_q <= flow_i;
    end
  end

  // stage b: magnitudes, height ratio operands, flow and sediment prep
  logic [AW-1:0]                  ax_b_d, ay_b_d;
  logic signed [HXW-1:0]          h_x, lo_x, hi_x, hs_x, span, rel, num, den;
  logic                           use_span, h_zero, h_sat;
  logic [FXW-1:0]                 fx;
  tsw_pkg::front_side_t           side_b_d;

  always_comb begin
    ax_b_d   = dx_a_q[DW-1] ? AW'(-dx_a_q) : AW'(dx_a_q);
    ay_b_d   = dy_a_q[DW-1] ? AW'(-dy_a_q) : AW'(dy_a_q);
    h_x      = HXW'(h_a_q);
    lo_x     = HXW'(cfg_i.range_low);
    hi_x     = HXW'(cfg_i.range_high);
    hs_x     = $signed(HXW'(cfg_i.height_scale));
    span     = hi_x - lo_x;
    rel      = h_x - lo_x;
    use_span = cfg_i.range_valid && (span > 0);
    if (use_span) begin
      num    = rel;
      den    = span;
      h_zero = (rel <= 0);
    end else begin
      num    = h_x;
      den    = hs_x;
      h_zero = (hs_x == 0) || (h_x <= 0);
    end
    h_sat = !h_zero && (num >= den);

    fx = (FXW'(flow_a_q) << WEIGHT_FRAC_BITS) >> tsw_pkg::FLOW_SHIFT;

    side_b_d            = '0;
    side_b_d.h_num      = (h_zero || h_sat) ? '0 : tsw_pkg::HDIV_W'(num);
    side_b_d.h_den      = tsw_pkg::HDIV_W'(den);
    side_b_d.h_zero     = h_zero;
    side_b_d.h_sat      = h_sat;
    side_b_d.flow_w     = (fx > FXW'(WLIM)) ? WLIM : tsw_pkg::WEIGHT_W'(fx);
  end

  always_ff @(posedge clk_i) begin
    if (!stall[1] && v_q[0]) begin
      ax_b_q      <= ax_b_d;
      ay_b_q      <= ay_b_d;
      sed_sat_b_q <= (sed_a_q >= tsw_pkg::SED_W'(tsw_pkg::SED_SAT_LIM));
      sedv_b_q    <= tsw_pkg::SEDV_W'(sed_a_q[tsw_pkg::SED_KEEP-1:0])
                     << (WEIGHT_FRAC_BITS - tsw_pkg::Q_FRAC);
      side_b_q    <= side_b_d;
    end
  end

  // stage c: range reduction of wide gradients, sediment reciprocal product
  logic [AW-1:0]             m_c;
  logic [tsw_pkg::EXP_W-1:0] e_c_d;

  always_comb begin
    m_c   = ax_b_q | ay_b_q;
    e_c_d = '0;
    for (int i = 0; i < EMAX; i++) begin
      if ((m_c >> (i + tsw_pkg::SQ_W)) != '0) begin
        e_c_d = tsw_pkg::EXP_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall[2] && v_q[1]) begin
      bx_c_q      <= tsw_pkg::SQ_W'(ax_b_q >> e_c_d);
      by_c_q      <= tsw_pkg::SQ_W'(ay_b_q >> e_c_d);
      e_c_q       <= e_c_d;
      sed_sat_c_q <= sed_sat_b_q;
      sedp_c_q    <= tsw_pkg::SED_PROD_W'(sedv_b_q) *
                     tsw_pkg::SED_PROD_W'(tsw_pkg::SED_RECIP);
      side_c_q    <= side_b_q;
    end
  end

  // stage d: squares, sediment weight
  tsw_pkg::front_side_t side_d_d;

  always_comb begin
    side_d_d       = side_c_q;
    side_d_d.sed_w = sed_sat_c_q ? WLIM :
                     tsw_pkg::WEIGHT_W'(sedp_c_q >> tsw_pkg::SED_RECIP_SH);
  end

  always_ff @(posedge clk_i) begin
    if (!stall[3] && v_q[2]) begin
      sqx_d_q  <= tsw_pkg::SQ2_W'(bx_c_q) * tsw_pkg::SQ2_W'(bx_c_q);
      sqy_d_q  <= tsw_pkg::SQ2_W'(by_c_q) * tsw_pkg::SQ2_W'(by_c_q);
      e_d_q    <= e_c_q;
      side_d_q <= side_d_d;
    end
  end

  // stage e: sum of squares, fraction bits kept for the root
  logic [tsw_pkg::SQ_SUM_W-1:0] q_e;
  logic [tsw_pkg::SHR_W-1:0]    sh_e;
  tsw_pkg::front_side_t         side_e_d;

  always_comb begin
    q_e  = tsw_pkg::SQ_SUM_W'(sqx_d_q) + tsw_pkg::SQ_SUM_W'(sqy_d_q);
    sh_e = '0;
    for (int k = 1; k <= tsw_pkg::ROOT_FRAC; k++) begin
      if ((q_e >> (tsw_pkg::ROOT_IN_W - 2 * k)) == '0) begin
        sh_e = tsw_pkg::SHR_W'(2 * k);
      end
    end
    side_e_d            = side_d_q;
    side_e_d.root_shift = tsw_pkg::SHR_W'(e_d_q) + tsw_pkg::SHR_W'(tsw_pkg::ROOT_FRAC)
                          - (sh_e >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (!stall[4] && v_q[3]) begin
      n_e_q    <= tsw_pkg::ROOT_IN_W'(q_e) << sh_e;
      side_e_q <= side_e_d;
    end
  end

  assign radicand_o = n_e_q;
  assign side_o     = side_e_q;

endmodule

// ===== design/tsw_root_pipe.sv =====
// ----------------------------------------------------------------------------
// tsw_root_pipe
// integer square root, one result bit per register stage
// ----------------------------------------------------------------------------
module tsw_root_pipe #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tsw_pkg::ROOT_IN_W-1:0] radicand_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tsw_pkg::ROOT_W-1:0]    root_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam int unsigned NST = tsw_pkg::ROOT_STEPS;
  localparam int unsigned RW  = tsw_pkg::ROOT_IN_W;

  logic [NST-1:0]    v_q;
  logic [NST-1:0]    stall;
  logic [RW-1:0]     n_q [NST];
  logic [RW-1:0]     r_q [NST];
  logic [SIDE_W-1:0] s_q [NST];
  logic [RW-1:0]     n_s [NST];
  logic [RW-1:0]     r_s [NST];
  logic [SIDE_W-1:0] s_s [NST];
  logic [NST-1:0]    v_s;

  always_comb begin
    stall[NST-1] = v_q[NST-1] && out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      stall[k] = v_q[k] && stall[k+1];
    end
  end

  assign in_stall_o  = stall[0];
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (!stall[k]) begin
          v_q[k] <= v_s[k];
        end
      end
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * k);

    logic [RW:0]   trial;
    logic [RW-1:0] n_d, r_d;

    if (k == 0) begin : g_first
      assign n_s[k] = radicand_i;
      assign r_s[k] = '0;
      assign s_s[k] = side_i;
      assign v_s[k] = in_valid_i;
    end else begin : g_next
      assign n_s[k] = n_q[k-1];
      assign r_s[k] = r_q[k-1];
      assign s_s[k] = s_q[k-1];
      assign v_s[k] = v_q[k-1];
    end

    always_comb begin
      trial = (RW + 1)'(r_s[k]) + (RW + 1)'(BIT);
      if ((RW + 1)'(n_s[k]) >= trial) begin
        n_d = RW'((RW + 1)'(n_s[k]) - trial);
        r_d = (r_s[k] >> 1) + BIT;
      end else begin
        n_d = n_s[k];
        r_d = r_s[k] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!stall[k] && v_s[k]) begin
        n_q[k] <= n_d;
        r_q[k] <= r_d;
        s_q[k] <= s_s[k];
      end
    end
  end

  assign root_o = tsw_pkg::ROOT_W'(r_q[NST-1]);
  assign side_o = s_q[NST-1];

endmodule

// ===== design/tsw_div_pipe.sv =====
// ----------------------------------------------------------------------------
// tsw_div_pipe
// restoring fraction divider, two lanes, one quotient bit per stage
// ----------------------------------------------------------------------------
module tsw_div_pipe #(
  parameter int unsigned STEPS  = tsw_pkg::WEIGHT_FRAC_DEF,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  logic [tsw_pkg::LANES-1:0][tsw_pkg::DIV_W-1:0] num_i,
  input  logic [tsw_pkg::LANES-1:0][tsw_pkg::DIV_W-1:0] den_i,
  input  logic [SIDE_W-1:0]                           side_i,
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output logic [tsw_pkg::LANES-1:0][STEPS-1:0]        quo_o,
  output logic [SIDE_W-1:0]                           side_o
);

  localparam int unsigned L  = tsw_pkg::LANES;
  localparam int unsigned DW = tsw_pkg::DIV_W;

  typedef logic [L-1:0][DW-1:0]    lane_t;
  typedef logic [L-1:0][STEPS-1:0] quo_t;

  logic [STEPS-1:0]  v_q;
  logic [STEPS-1:0]  stall;
  lane_t             rem_q [STEPS];
  lane_t             den_q [STEPS];
  quo_t              quo_q [STEPS];
  logic [SIDE_W-1:0] s_q   [STEPS];
  lane_t             rem_s [STEPS];
  lane_t             den_s [STEPS];
  quo_t              quo_s [STEPS];
  logic [SIDE_W-1:0] s_s   [STEPS];
  logic [STEPS-1:0]  v_s;

  always_comb begin
    stall[STEPS-1] = v_q[STEPS-1] && out_stall_i;
    for (int k = STEPS - 2; k >= 0; k--) begin
      stall[k] = v_q[k] && stall[k+1];
    end
  end

  assign in_stall_o  = stall[0];
  assign out_valid_o = v_q[STEPS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < STEPS; k++) begin
        if (!stall[k]) begin
          v_q[k] <= v_s[k];
        end
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    lane_t      rem_d;
    quo_t       quo_d;
    logic [DW:0] dbl;

    if (k == 0) begin : g_first
      assign rem_s[k] = num_i;
      assign den_s[k] = den_i;
      assign quo_s[k] = '0;
      assign s_s[k]   = side_i;
      assign v_s[k]   = in_valid_i;
    end else begin : g_next
      assign rem_s[k] = rem_q[k-1];
      assign den_s[k] = den_q[k-1];
      assign quo_s[k] = quo_q[k-1];
      assign s_s[k]   = s_q[k-1];
      assign v_s[k]   = v_q[k-1];
    end

    always_comb begin
      dbl = '0;
      for (int l = 0; l < L; l++) begin
        dbl = {rem_s[k][l], 1'b0};
        if (dbl >= (DW + 1)'(den_s[k][l])) begin
          rem_d[l] = DW'(dbl - (DW + 1)'(den_s[k][l]));
          quo_d[l] = {quo_s[k][l][STEPS-2:0], 1'b1};
        end else begin
          rem_d[l] = DW'(dbl);
          quo_d[l] = {quo_s[k][l][STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (!stall[k] && v_s[k]) begin
        rem_q[k] <= rem_d;
        den_q[k] <= den_s[k];
        quo_q[k] <= quo_d;
        s_q[k]   <= s_s[k];
      end
    end
  end

  assign quo_o  = quo_q[STEPS-1];
  assign side_o = s_q[STEPS-1];

endmodule

// ===== design/terrain_splat_weights_unit.sv =====
// ----------------------------------------------------------------------------
// terrain_splat_weights_unit
// per cell rock, height, flow and sediment splat weights; unless res_o stalls, one cell per clock
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one terrain cell per word: centre height, the four axis
//   neighbours (edge clamping done upstream), sediment depth and flow level.
//   res_o returns one word of four Q1.15 weights per cell, in order.
//   cfg_i writes the registers (cell size, span low/high/valid, height
//   scale); it is always ready and must only be used while the pipe is empty.
// throughput: one word per clock while res_o is ready.
// pipeline: the front end, the 31 stage square root, stages f and g, the
//   one-bit-per-stage fraction divider and the output register, in that order.
// reset: all pipeline valid bits clear, registers take their reset values.
// stall: a stalled receiver holds the output register; stages behind it
//   keep filling bubbles, so in_i.ready only falls once every stage holds
//   a word. nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module terrain_splat_weights_unit #(
  parameter int unsigned HEIGHT_WIDTH     = tsw_pkg::HEIGHT_WIDTH_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = tsw_pkg::WEIGHT_FRAC_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tsw_in_if.sink       in_i,
  tsw_res_if.source    res_o,
  tsw_cfg_if.sink      cfg_i
);

  localparam int unsigned FSW = $bits(tsw_pkg::front_side_t);
  localparam int unsigned DSW = $bits(tsw_pkg::div_side_t);
  localparam logic [tsw_pkg::WEIGHT_W-1:0] WLIM =
    tsw_pkg::weight_limit(WEIGHT_FRAC_BITS);

  // configuration registers
  tsw_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_size    <= tsw_pkg::CELL_SIZE_RST;
      cfg_q.range_low    <= '0;
      cfg_q.range_high   <= '0;
      cfg_q.range_valid  <= 1'b0;
      cfg_q.height_scale <= tsw_pkg::HEIGHT_SCALE_RST;
    end else if (cfg_i.valid) begin
      case (tsw_pkg::cfg_reg_e'(cfg_i.index))
        tsw_pkg::REG_CELL_SIZE:    cfg_q.cell_size    <= cfg_i.data;
        tsw_pkg::REG_RANGE_LOW:    cfg_q.range_low    <= $signed(cfg_i.data);
        tsw_pkg::REG_RANGE_HIGH:   cfg_q.range_high   <= $signed(cfg_i.data);
        tsw_pkg::REG_RANGE_VALID:  cfg_q.range_valid  <= cfg_i.data[0];
        tsw_pkg::REG_HEIGHT_SCALE: cfg_q.height_scale <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // front end: gradients, magnitudes, squares, height/flow/sediment prep
  logic                          fr_stall, fr_valid;
  logic [tsw_pkg::ROOT_IN_W-1:0] fr_radicand;
  tsw_pkg::front_side_t          fr_side;
  logic                          rt_stall, rt_valid;
  logic [tsw_pkg::ROOT_W-1:0]    rt_root;
  logic [FSW-1:0]                rt_side_raw;
  tsw_pkg::front_side_t          rt_side;

  assign in_i.ready = !fr_stall;

  tsw_front #(
    .HEIGHT_WIDTH     (HEIGHT_WIDTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_stall_o  (fr_stall),
    .center_i    (in_i.center_height),
    .left_i      (in_i.left_height),
    .right_i     (in_i.right_height),
    .lower_i     (in_i.lower_height),
    .upper_i     (in_i.upper_height),
    .sed_i       (in_i.sediment_depth),
    .flow_i      (in_i.flow_level),
    .out_valid_o (fr_valid),
    .out_stall_i (rt_stall),
    .radicand_o  (fr_radicand),
    .side_o      (fr_side)
  );

  // slope magnitude root, side words ride along
  logic stall_f, stall_g, stall_o, dv_stall, dv_valid;

  tsw_root_pipe #(
    .SIDE_W (FSW)
  ) u_root (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_stall_o  (rt_stall),
    .radicand_i  (fr_radicand),
    .side_i      (fr_side),
    .out_valid_o (rt_valid),
    .out_stall_i (stall_f),
    .root_o      (rt_root),
    .side_o      (rt_side_raw)
  );

  assign rt_side = tsw_pkg::front_side_t'(rt_side_raw);

  // stage f: slope scaling and rock ramp terms
  logic                        v_f_q, v_g_q, v_o_q;
  logic [tsw_pkg::HI_W-1:0]    hi_f_q;
  logic [tsw_pkg::DIV_W-1:0]   lo_f_q, den_f_q;
  tsw_pkg::front_side_t        side_f_q;
  logic [tsw_pkg::SLOPE_W-1:0] slope_f;
  logic [tsw_pkg::T_W-1:0]     t_f;

  always_comb begin
    slope_f = tsw_pkg::SLOPE_W'(rt_root) << rt_side.root_shift;
    t_f     = tsw_pkg::T_W'((cfg_q.cell_size == '0) ? tsw_pkg::REG_W'(1) :
                            cfg_q.cell_size) << 1;
  end

  // stage g: zero and saturation tests, divider lanes
  logic [tsw_pkg::HI_W-1:0]                       num_g;
  logic                                           r_zero_g, r_sat_g;
  logic [tsw_pkg::LANES-1:0][tsw_pkg::DIV_W-1:0]  dnum_g_q, dden_g_q;
  tsw_pkg::div_side_t                             dside_g_q;

  always_comb begin
    r_zero_g = (tsw_pkg::HI_W'(lo_f_q) >= hi_f_q);
    num_g    = hi_f_q - tsw_pkg::HI_W'(lo_f_q);
    r_sat_g  = !r_zero_g && (num_g >= tsw_pkg::HI_W'(den_f_q));
  end

  // pipeline hold chain across the top level stages
  assign stall_o = v_o_q && !res_o.ready;
  assign stall_g = v_g_q && dv_stall;
  assign stall_f = v_f_q && stall_g;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_f_q <= 1'b0;
      v_g_q <= 1'b0;
      v_o_q <= 1'b0;
    end else begin
      if (!stall_f) v_f_q <= rt_valid;
      if (!stall_g) v_g_q <= v_f_q;
      if (!stall_o) v_o_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_f && rt_valid) begin
      hi_f_q   <= tsw_pkg::HI_W'(slope_f) * tsw_pkg::HI_W'(tsw_pkg::ROCK_GAIN);
      lo_f_q   <= tsw_pkg::DIV_W'(t_f) * tsw_pkg::DIV_W'(tsw_pkg::ROCK_LO_MUL);
      den_f_q  <= tsw_pkg::DIV_W'(t_f) * tsw_pkg::DIV_W'(tsw_pkg::ROCK_DEN_MUL);
      side_f_q <= rt_side;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_g && v_f_q) begin
      dnum_g_q[tsw_pkg::LANE_ROCK] <= (r_zero_g || r_sat_g) ? '0 :
                                      tsw_pkg::DIV_W'(num_g);
      dden_g_q[tsw_pkg::LANE_ROCK] <= den_f_q;
      dnum_g_q[tsw_pkg::LANE_HGT]  <= tsw_pkg::DIV_W'(side_f_q.h_num);
      dden_g_q[tsw_pkg::LANE_HGT]  <= tsw_pkg::DIV_W'(side_f_q.h_den);
      dside_g_q.r_zero <= r_zero_g;
      dside_g_q.r_sat  <= r_sat_g;
      dside_g_q.h_zero <= side_f_q.h_zero;
      dside_g_q.h_sat  <= side_f_q.h_sat;
      dside_g_q.flow_w <= side_f_q.flow_w;
      dside_g_q.sed_w  <= side_f_q.sed_w;
    end
  end

  // fraction dividers for rock and height
  logic [tsw_pkg::LANES-1:0][WEIGHT_FRAC_BITS-1:0] dv_quo;
  logic [DSW-1:0]                                  dv_side_raw;
  tsw_pkg::div_side_t                              dv_side;

  tsw_div_pipe #(
    .STEPS  (WEIGHT_FRAC_BITS),
    .SIDE_W (DSW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_g_q),
    .in_stall_o  (dv_stall),
    .num_i       (dnum_g_q),
    .den_i       (dden_g_q),
    .side_i      (dside_g_q),
    .out_valid_o (dv_valid),
    .out_stall_i (stall_o),
    .quo_o       (dv_quo),
    .side_o      (dv_side_raw)
  );

  assign dv_side = tsw_pkg::div_side_t'(dv_side_raw);

  // output register: flags select zero or full scale over the quotient
  logic [tsw_pkg::WEIGHT_W-1:0] rock_q, height_q, flow_q, sed_q;

  always_ff @(posedge clk_i) begin
    if (!stall_o && dv_valid) begin
      rock_q   <= dv_side.r_zero ? '0 : dv_side.r_sat ? WLIM :
                  tsw_pkg::WEIGHT_W'(dv_quo[tsw_pkg::LANE_ROCK]);
      height_q <= dv_side.h_zero ? '0 : dv_side.h_sat ? WLIM :
                  tsw_pkg::WEIGHT_W'(dv_quo[tsw_pkg::LANE_HGT]);
      flow_q   <= dv_side.flow_w;
      sed_q    <= dv_side.sed_w;
    end
  end

  assign res_o.valid           = v_o_q;
  assign res_o.rock_weight     = rock_q;
  assign res_o.height_weight   = height_q;
  assign res_o.flow_weight     = flow_q;
  assign res_o.sediment_weight = sed_q;

endmodule

// ===== bench/tb_terrain_splat_weights_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_terrain_splat_weights_unit
// drives terrain cells into the splat weight unit and checks every weight word
// against an exact integer predictor; runs several register settings and
// idling phases on both channels
// ----------------------------------------------------------------------------
module tb_terrain_splat_weights_unit;

  localparam int unsigned HW = tsw_pkg::HEIGHT_WIDTH_DEF;
  localparam int unsigned FB = tsw_pkg::WEIGHT_FRAC_DEF;
  localparam int unsigned PIPE_CYCLES = 38 + FB;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] rock;
    logic [15:0] hgt;
    logic [15:0] flow;
    logic [15:0] sed;
  } weights_t;

  typedef struct packed {
    logic signed [HW-1:0]      c, l, r, d, u;
    logic [tsw_pkg::SED_W-1:0]  sed;
    logic [tsw_pkg::FLOW_W-1:0] flow;
  } cell_t;

  // scoreboard: register copy, weight predictor, pending weight words
  class weight_board;
    longint unsigned cell_size = tsw_pkg::CELL_SIZE_RST;
    longint          span_lo = 0;
    longint          span_hi = 0;
    bit              span_ok = 0;
    longint unsigned hscale = tsw_pkg::HEIGHT_SCALE_RST;
    weights_t        pending[$];
    int              mismatches = 0;

    function void write_reg(tsw_pkg::cfg_reg_e idx, logic [tsw_pkg::REG_W-1:0] val);
      case (idx)
        tsw_pkg::REG_CELL_SIZE:    cell_size = val;
        tsw_pkg::REG_RANGE_LOW:    span_lo = longint'(signed'(val));
        tsw_pkg::REG_RANGE_HIGH:   span_hi = longint'(signed'(val));
        tsw_pkg::REG_RANGE_VALID:  span_ok = val[0];
        tsw_pkg::REG_HEIGHT_SCALE: hscale = val;
        default: ;
      endcase
    endfunction

    function longint unsigned frac_of(longint unsigned num, longint unsigned den);
      longint unsigned w;
      if (num >= den) w = 1 << FB;
      else w = (num << FB) / den;
      return (w > 65535) ? 65535 : w;
    endfunction

    function longint unsigned root_of(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      for (int k = 31; k >= 0; k--) begin
        b = r | (64'd1 << k);
        if (b * b <= n) r = b;
      end
      return r;
    endfunction

    function void note_cell(cell_t x);
      weights_t        w;
      longint          dx, dy, rel, span;
      longint unsigned q, s, t, hi, lo;
      dx = longint'(x.r) - longint'(x.l);
      dy = longint'(x.u) - longint'(x.d);
      // differences stay below 2^25 at this width, so all 6 fraction bits of the root are kept
      q = dx * dx + dy * dy;
      s = root_of(q << 12);
      t = 2 * ((cell_size == 0) ? 1 : cell_size);
      hi = 100 * s;
      lo = 2304 * t;
      w.rock = (hi <= lo) ? 16'd0 : 16'(frac_of(hi - lo, 3072 * t));
      span = span_hi - span_lo;
      if (span_ok && span > 0) begin
        rel = longint'(x.c) - span_lo;
        w.hgt = (rel <= 0) ? 16'd0 : 16'(frac_of(rel, span));
      end else if (hscale == 0 || x.c <= 0) begin
        w.hgt = 16'd0;
      end else begin
        w.hgt = 16'(frac_of(longint'(x.c), hscale));
      end
      q = (longint'(x.flow) << FB) >> 9;
      w.flow = (q > (1 << FB)) ? 16'(1 << FB) : 16'(q);
      q = (longint'(x.sed) << FB) / 768;
      w.sed = (q > (1 << FB)) ? 16'(1 << FB) : 16'(q);
      pending = {pending, w};
    endfunction

    function void check_word(weights_t got);
      weights_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected weight word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10)
          $display("weight mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                   exp_w.rock, exp_w.hgt, exp_w.flow, exp_w.sed,
                   got.rock, got.hgt, got.flow, got.sed);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  longint cycles = 0;
  int send_idle_pct = 0;   // chance of an idle cycle on the cell channel
  int recv_stall_pct = 0;  // chance of a stall on the weight channel

  tsw_in_if  cell_ch ();
  tsw_res_if wgt_ch ();
  tsw_cfg_if reg_ch ();

  weight_board board;

  terrain_splat_weights_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cell_ch.sink),
    .res_o (wgt_ch.source),
    .cfg_i (reg_ch.sink)
  );

  always #4 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_terrain_splat_weights_unit: FAIL");
      $finish;
    end
  end

  // weight word sampling at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && wgt_ch.valid && wgt_ch.ready)
      board.check_word({wgt_ch.rock_weight, wgt_ch.height_weight,
                        wgt_ch.flow_weight, wgt_ch.sediment_weight});
  end

  // receiver stalls, changed at the falling edge
  always @(negedge clk_i) begin
    wgt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(tsw_pkg::cfg_reg_e idx, logic [tsw_pkg::REG_W-1:0] val);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= val;
    do @(posedge clk_i); while (!reg_ch.ready);
    board.write_reg(idx, val);
    @(negedge clk_i);
    reg_ch.valid <= 1'b0;
  endtask

  // stops the cell channel, waits until every weight word is back plus the pipe latency
  task automatic drain();
    cell_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (PIPE_CYCLES + 4) @(negedge clk_i);
  endtask

  task automatic send_cell(cell_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      cell_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cell_ch.valid          <= 1'b1;
    cell_ch.center_height  <= x.c;
    cell_ch.left_height    <= x.l;
    cell_ch.right_height   <= x.r;
    cell_ch.lower_height   <= x.d;
    cell_ch.upper_height   <= x.u;
    cell_ch.sediment_depth <= x.sed;
    cell_ch.flow_level     <= x.flow;
    do @(posedge clk_i); while (!cell_ch.ready);
    board.note_cell(x);
    @(negedge clk_i);
  endtask

  task automatic idle_cells();
    cell_ch.valid <= 1'b0;
  endtask

  function automatic logic [HW-1:0] rand_height();
    case ($urandom_range(3))
      0: return HW'($urandom);
      1: return HW'($urandom_range(8192)) - HW'(4096);
      2: return HW'($urandom_range(40000));
      default: return HW'($urandom_range(20000));
    endcase
  endfunction

  // slope-shaped cell: neighbours near the centre so rock lands on the ramp
  function automatic cell_t rand_cell();
    cell_t x;
    int    spread;
    x.c = rand_height();
    spread = (1 << $urandom_range(12));
    x.l = x.c + HW'($urandom_range(spread)) - HW'(spread / 2);
    x.r = x.c + HW'($urandom_range(spread)) - HW'(spread / 2);
    x.d = x.c + HW'($urandom_range(spread)) - HW'(spread / 2);
    x.u = x.c + HW'($urandom_range(spread)) - HW'(spread / 2);
    if ($urandom_range(4) == 0) begin
      x.l = HW'($urandom); x.r = HW'($urandom);
      x.d = HW'($urandom); x.u = HW'($urandom);
    end
    x.sed  = ($urandom_range(1)) ? tsw_pkg::SED_W'($urandom_range(1000)) :
                                   tsw_pkg::SED_W'($urandom);
    x.flow = ($urandom_range(1)) ? tsw_pkg::FLOW_W'($urandom_range(600)) :
                                   tsw_pkg::FLOW_W'($urandom);
    return x;
  endfunction

  task automatic random_phase(int count, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) send_cell(rand_cell());
    idle_cells();
  endtask

  localparam logic signed [HW-1:0] HMAX = {1'b0, {(HW-1){1'b1}}};
  localparam logic signed [HW-1:0] HMIN = {1'b1, {(HW-1){1'b0}}};

  initial begin
    board = new();
    cell_ch.valid = 1'b0;
    cell_ch.center_height = '0;
    cell_ch.left_height = '0;
    cell_ch.right_height = '0;
    cell_ch.lower_height = '0;
    cell_ch.upper_height = '0;
    cell_ch.sediment_depth = '0;
    cell_ch.flow_level = '0;
    reg_ch.valid = 1'b0;
    reg_ch.index = tsw_pkg::REG_CELL_SIZE;
    reg_ch.data = '0;
    wgt_ch.ready = 1'b1;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset registers, flat, extremes, slope ramp ends, saturation
    send_cell('{c: 0, l: 0, r: 0, d: 0, u: 0, sed: 0, flow: 0});
    send_cell('{c: HMAX, l: HMIN, r: HMAX, d: HMIN, u: HMAX,
                sed: '1, flow: '1});
    send_cell('{c: HMIN, l: HMAX, r: HMIN, d: HMAX, u: HMIN, sed: 768, flow: 512});
    // slope at the ramp ends, near tan 20 and tan 40 at cell size 1.0: dx = 0.72 and 1.68 cells
    send_cell('{c: 10240, l: 0, r: 184, d: 0, u: 0, sed: 767, flow: 511});
    send_cell('{c: 10239, l: 0, r: 430, d: 0, u: 0, sed: 1, flow: 1});
    send_cell('{c: 10241, l: 0, r: 0, d: 100, u: 300, sed: 769, flow: 513});
    send_cell('{c: -1, l: 5, r: -5, d: 7, u: -7, sed: 3, flow: 2});
    drain();

    // zero cell size treated as one step; zero height scale
    write_reg(tsw_pkg::REG_CELL_SIZE, 24'd0);
    write_reg(tsw_pkg::REG_HEIGHT_SCALE, 24'd0);
    send_cell('{c: 500, l: 0, r: 1, d: 0, u: 0, sed: 0, flow: 0});
    send_cell('{c: 500, l: 0, r: 0, d: 0, u: 0, sed: 0, flow: 0});
    drain();

    // valid span, then an empty and an inverted span
    write_reg(tsw_pkg::REG_CELL_SIZE, 24'hFFFFFF);
    write_reg(tsw_pkg::REG_RANGE_LOW, 24'hFFF000);
    write_reg(tsw_pkg::REG_RANGE_HIGH, 24'h001000);
    write_reg(tsw_pkg::REG_RANGE_VALID, 24'd1);
    write_reg(tsw_pkg::REG_HEIGHT_SCALE, 24'hFFFFFF);
    send_cell('{c: -4096, l: HMIN, r: HMAX, d: HMIN, u: HMAX, sed: 0, flow: 0});
    send_cell('{c: 0, l: 0, r: 0, d: 0, u: 0, sed: 0, flow: 0});
    send_cell('{c: 4096, l: 0, r: 0, d: 0, u: 0, sed: 0, flow: 0});
    send_cell('{c: 5000, l: 0, r: 0, d: 0, u: 0, sed: 0, flow: 0});
    drain();
    write_reg(tsw_pkg::REG_RANGE_HIGH, 24'hFFF000);
    send_cell('{c: 100, l: 0, r: 0, d: 0, u: 0, sed: 0, flow: 0});
    drain();
    write_reg(tsw_pkg::REG_RANGE_HIGH, 24'hFF0000);
    send_cell('{c: 100, l: 0, r: 0, d: 0, u: 0, sed: 0, flow: 0});
    idle_cells();
    drain();

    // random phases across settings and idling mixes
    write_reg(tsw_pkg::REG_CELL_SIZE, 24'd256);
    write_reg(tsw_pkg::REG_RANGE_VALID, 24'd0);
    write_reg(tsw_pkg::REG_HEIGHT_SCALE, 24'd10240);
    random_phase(150, 0, 0);
    drain();
    write_reg(tsw_pkg::REG_CELL_SIZE, 24'd64);
    write_reg(tsw_pkg::REG_RANGE_LOW, 24'd0);
    write_reg(tsw_pkg::REG_RANGE_HIGH, 24'd20000);
    write_reg(tsw_pkg::REG_RANGE_VALID, 24'd1);
    random_phase(150, 64, 0);
    // hold off until every weight word is back
    drain();
    write_reg(tsw_pkg::REG_CELL_SIZE, 24'd1);
    random_phase(150, 0, 64);
    drain();
    write_reg(tsw_pkg::REG_CELL_SIZE, 24'd1024);
    write_reg(tsw_pkg::REG_RANGE_VALID, 24'd0);
    write_reg(tsw_pkg::REG_HEIGHT_SCALE, 24'd1);
    random_phase(150, 6, 6);
    drain();
    write_reg(tsw_pkg::REG_CELL_SIZE, 24'd300);
    write_reg(tsw_pkg::REG_HEIGHT_SCALE, 24'd40000);
    random_phase(150, 30, 30);
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb_terrain_splat_weights_unit: PASS");
    end else begin
      $display("tb_terrain_splat_weights_unit: FAIL");
    end
    $finish;
  end

endmodule
